>>> rtl/page_bitmap_allocator_top_assert.svh
// Assertion macros shared by the page allocator checker.
// Each macro expands to one labeled concurrent assertion clocked on the given clock.
`ifndef PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define PBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// Next-cycle implication, switched off while reset is asserted.
`define PBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page allocator check failed");

// Next-cycle implication that also holds across reset.
`define PBA_ASSERT_NXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

>>> rtl/pba_pkg.sv
// Package for the page bitmap allocator: sizes, codes, state and control types.
// No dependencies; every other file of the block but pba_ram and the assertion header imports it.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    localparam int unsigned MAX_PAGES  = 65536;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned BIT_IDX_W  = $clog2(WORD_W);
    localparam int unsigned MAP_WORDS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int unsigned WIDX_W     = $clog2(MAP_WORDS);
    localparam int unsigned CUR_W      = WIDX_W + 1;
    localparam int unsigned PAGE_W     = 16;
    localparam int unsigned TOTAL_W    = 17;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [TOTAL_W-1:0]    PAGE_TOTAL_RST = TOTAL_W'(65536);
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;
    localparam logic [APB_ADDR_W-1:0] REG_PAGE_TOTAL = '0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_NO_PAGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_EVAL,
        S_FREE_RD,
        S_FREE_EVAL,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_NEXT,
        RD_PAGE
    } t_rd_sel;

    typedef struct packed {
        logic    clr_step;
        logic    take_item;
        logic    scan_next;
        logic    scan_wrap;
        logic    alloc_commit;
        logic    free_commit;
        logic    res_load;
        t_status res_status;
        logic    out_load;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic cur_in_range;
        logic next_in_range;
        logic pass2;
        logic hit;
        logic free_ok;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/pba_req_if.sv
// Request channel of the page allocator: command and page number with valid/ready.
// Depends on pba_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pba_req_if;
    import pba_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output command, output page_number, input ready);
    modport sink (input valid, input command, input page_number, output ready);
endinterface

`default_nettype wire

>>> rtl/pba_rsp_if.sv
// Response channel of the page allocator: status, granted page and free count.
// Depends on pba_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pba_rsp_if;
    import pba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   granted_page;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output granted_page, output free_count,
                    input ready);
    modport sink (input valid, input status, input granted_page, input free_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

>>> rtl/pba_ctrl.sv
// Controller of the page allocator: sequences clearing, word scans, frees and the
// response hand-off. Depends on pba_pkg; drives pba_dp through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module pba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_command,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pba_pkg::t_dp_cmd  o_cmd,
    input  pba_pkg::t_dp_stat i_stat
);
    import pba_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel     = RD_CUR;
        o_cmd.res_status = ST_DONE;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state = (i_in_command == CMD_FREE) ? S_FREE_RD : S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                o_cmd.rd_sel = RD_CUR;
                if (i_stat.cur_in_range) begin
                    n_state = S_ALLOC_EVAL;
                end else if (!i_stat.pass2) begin
                    o_cmd.scan_wrap = 1'b1;
                end else begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NO_PAGE;
                    n_state = S_RESP;
                end
            end
            S_ALLOC_EVAL: begin
                // The next word is fetched while this one is checked.
                o_cmd.rd_sel = RD_NEXT;
                if (i_stat.hit) begin
                    o_cmd.alloc_commit = 1'b1;
                    o_cmd.res_load     = 1'b1;
                    o_cmd.res_status   = ST_DONE;
                    n_state = S_RESP;
                end else if (i_stat.next_in_range) begin
                    o_cmd.scan_next = 1'b1;
                end else if (!i_stat.pass2) begin
                    o_cmd.scan_wrap = 1'b1;
                    n_state = S_ALLOC_RD;
                end else begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NO_PAGE;
                    n_state = S_RESP;
                end
            end
            S_FREE_RD: begin
                o_cmd.rd_sel = RD_PAGE;
                n_state = S_FREE_EVAL;
            end
            S_FREE_EVAL: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.free_ok) begin
                    o_cmd.free_commit = 1'b1;
                    o_cmd.res_status  = ST_DONE;
                end else begin
                    o_cmd.res_status  = ST_IGNORED;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

`default_nettype wire

>>> rtl/pba_dp.sv
// Datapath of the page allocator: usage bitmap RAM, scan cursor, hint, free count
// and result registers. Depends on pba_pkg and pba_ram; steered by pba_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module pba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pba_pkg::t_dp_cmd              i_cmd,
    output pba_pkg::t_dp_stat             o_stat,
    input  logic [pba_pkg::PAGE_W-1:0]    i_page_number,
    input  logic [pba_pkg::TOTAL_W-1:0]   i_page_total,
    output logic [pba_pkg::STATUS_W-1:0]  o_status,
    output logic [pba_pkg::PAGE_W-1:0]    o_granted_page,
    output logic [pba_pkg::COUNT_W-1:0]   o_free_count
);
    import pba_pkg::*;

    // Lowest set bit of a 64-bit word as two 8-way priority picks.
    function automatic logic [BIT_IDX_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
        logic [7:0] grp_nz;
        logic [7:0] grp_bits;
        logic [2:0] grp;
        logic [2:0] pos;
        for (int i = 0; i < 8; i++) begin
            grp_nz[i] = |v[i*8 +: 8];
        end
        grp = '0;
        for (int i = 7; i >= 0; i--) begin
            if (grp_nz[i]) begin
                grp = 3'(i);
            end
        end
        grp_bits = v[grp*8 +: 8];
        pos = '0;
        for (int i = 7; i >= 0; i--) begin
            if (grp_bits[i]) begin
                pos = 3'(i);
            end
        end
        return {grp, pos};
    endfunction

    logic [CUR_W-1:0]   r_cur, n_cur;
    logic               r_pass, n_pass;
    logic [PAGE_W-1:0]  r_hint, n_hint;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PAGE_W-1:0]  r_page;
    t_status            r_res_status;
    logic [PAGE_W-1:0]  r_res_page;
    t_status            r_out_status;
    logic [PAGE_W-1:0]  r_out_page;
    logic [COUNT_W-1:0] r_out_count;

    logic               ram_we;
    logic [WIDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WIDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic [TOTAL_W-1:0]   total_act;
    logic [TOTAL_W:0]     total_round;
    logic [CUR_W-1:0]     words;
    logic [CUR_W:0]       cur_plus1;
    logic [BIT_IDX_W-1:0] low_free;
    logic [PAGE_W-1:0]    alloc_page;
    logic [TOTAL_W-1:0]   page_after;
    logic [PAGE_W-1:0]    hint_next;
    logic [WORD_W-1:0]    alloc_mask;
    logic [WORD_W-1:0]    clr_mask;
    logic                 word_full;
    logic                 page_in_range;

    pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        total_act   = (i_page_total > TOTAL_W'(MAX_PAGES)) ? TOTAL_W'(MAX_PAGES)
                                                           : i_page_total;
        total_round = {1'b0, total_act} + (TOTAL_W + 1)'(WORD_W - 1);
        words       = total_round[BIT_IDX_W +: CUR_W];
        cur_plus1   = {1'b0, r_cur} + (CUR_W + 1)'(1);

        word_full  = &ram_rdata;
        low_free   = lowest_one(~ram_rdata);
        alloc_page = {r_cur[WIDX_W-1:0], low_free};
        alloc_mask = WORD_W'(1) << low_free;
        page_after = {1'b0, alloc_page} + TOTAL_W'(1);
        hint_next  = (page_after >= total_act) ? PAGE_W'(1) : page_after[PAGE_W-1:0];

        clr_mask      = WORD_W'(1) << r_page[BIT_IDX_W-1:0];
        page_in_range = (r_page != '0) && ({1'b0, r_page} < total_act);

        o_stat.clr_last      = (r_cur[WIDX_W-1:0] == WIDX_W'(MAP_WORDS - 1));
        o_stat.cur_in_range  = (r_cur < words);
        o_stat.next_in_range = (cur_plus1 < {1'b0, words});
        o_stat.pass2         = r_pass;
        // A word is skipped when its lowest free bit is page zero or past the total.
        o_stat.hit           = !word_full && (alloc_page != '0) &&
                               ({1'b0, alloc_page} < total_act);
        o_stat.free_ok       = page_in_range && ((ram_rdata & clr_mask) != '0);
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_CUR:  ram_raddr = r_cur[WIDX_W-1:0];
            RD_NEXT: ram_raddr = r_cur[WIDX_W-1:0] + WIDX_W'(1);
            RD_PAGE: ram_raddr = r_page[PAGE_W-1:BIT_IDX_W];
            default: ram_raddr = r_cur[WIDX_W-1:0];
        endcase

        ram_we = i_cmd.clr_step || i_cmd.alloc_commit || i_cmd.free_commit;
        if (i_cmd.clr_step) begin
            ram_waddr = r_cur[WIDX_W-1:0];
            ram_wdata = '1;
        end else if (i_cmd.alloc_commit) begin
            ram_waddr = r_cur[WIDX_W-1:0];
            ram_wdata = ram_rdata | alloc_mask;
        end else begin
            ram_waddr = r_page[PAGE_W-1:BIT_IDX_W];
            ram_wdata = ram_rdata & ~clr_mask;
        end
    end

    always_comb begin
        n_cur   = r_cur;
        n_pass  = r_pass;
        n_hint  = r_hint;
        n_count = r_count;
        if (i_cmd.clr_step) begin
            n_cur = r_cur + CUR_W'(1);
        end else if (i_cmd.take_item) begin
            n_cur  = {1'b0, r_hint[PAGE_W-1:BIT_IDX_W]};
            n_pass = 1'b0;
        end else if (i_cmd.scan_wrap) begin
            n_cur  = '0;
            n_pass = 1'b1;
        end else if (i_cmd.scan_next) begin
            n_cur = cur_plus1[CUR_W-1:0];
        end
        if (i_cmd.alloc_commit) begin
            n_hint = hint_next;
            if (r_count != '0) begin
                n_count = r_count - COUNT_W'(1);
            end
        end else if (i_cmd.free_commit) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_pass  <= 1'b0;
            r_hint  <= PAGE_W'(1);
            r_count <= '0;
        end else begin
            r_cur   <= n_cur;
            r_pass  <= n_pass;
            r_hint  <= n_hint;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_page <= i_page_number;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_page   <= i_cmd.alloc_commit ? alloc_page : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_page   <= r_res_page;
            r_out_count  <= r_count;
        end
    end

    assign o_status       = r_out_status;
    assign o_granted_page = r_out_page;
    assign o_free_count   = r_out_count;
endmodule

`default_nettype wire

>>> rtl/page_bitmap_allocator_top.sv
// Next-fit physical page allocator over a used/free bitmap of 1024 words of 64 pages,
// held in a single-port-read RAM that is scanned one word per cycle. After reset a
// clearing pass marks every page used; no request beat is taken during it, while
// register writes are. A free reads the bitmap word of its page, checks it and then
// loads its response beat. An allocate grows longer with each bitmap word it visits
// and when the scan wraps to word 0, so its length is set by how far the next free
// page lies from the search hint. One request is in flight at a time; a finished
// response waits in an output register, so a new request is accepted while the
// previous response is still pending. page_total sits at address 0.
`timescale 1ns / 1ps
`default_nettype none

module page_bitmap_allocator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pba_req_if.sink                            req,
    pba_rsp_if.source                          rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pba_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pba_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pba_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import pba_pkg::*;

    logic [TOTAL_W-1:0] r_page_total;
    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_total <= PAGE_TOTAL_RST;
        end else if (psel && penable && pwrite && pready && (paddr == REG_PAGE_TOTAL)) begin
            r_page_total <= pwdata[TOTAL_W-1:0];
        end
    end

    assign prdata = (paddr == REG_PAGE_TOTAL) ? APB_DATA_W'(r_page_total) : '0;

    pba_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (req.valid),
        .i_in_command (req.command),
        .o_in_ready   (req.ready),
        .o_out_valid  (rsp.valid),
        .i_out_ready  (rsp.ready),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat)
    );

    pba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_page_number  (req.page_number),
        .i_page_total   (r_page_total),
        .o_status       (rsp.status),
        .o_granted_page (rsp.granted_page),
        .o_free_count   (rsp.free_count)
    );
endmodule

`default_nettype wire

>>> rtl/pba_checker.sv
// Port-level checker for the page allocator, bound to the top level.
// Depends on pba_pkg and the assertion macros in page_bitmap_allocator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "page_bitmap_allocator_top_assert.svh"

module pba_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [pba_pkg::STATUS_W-1:0]     i_rsp_status,
    input logic [pba_pkg::PAGE_W-1:0]       i_rsp_granted_page,
    input logic [pba_pkg::COUNT_W-1:0]      i_rsp_free_count
);
    import pba_pkg::*;

    // A failed or ignored command never reports a page.
    `PBA_ASSERT_IMP(a_no_page_on_fail, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != ST_DONE), i_rsp_granted_page == '0)

    // The bitmap clearing pass keeps the request side closed right after reset.
    `PBA_ASSERT_NXT_NR(a_busy_after_reset, i_clk, !i_rst_n, !i_req_ready)

    // Only one command is worked on at a time.
    `PBA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // A stalled response beat holds its valid, free count and granted page.
    `PBA_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_free_count) && $stable(i_rsp_granted_page))
endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (req.valid),
    .i_req_ready        (req.ready),
    .i_rsp_valid        (rsp.valid),
    .i_rsp_ready        (rsp.ready),
    .i_rsp_status       (rsp.status),
    .i_rsp_granted_page (rsp.granted_page),
    .i_rsp_free_count   (rsp.free_count)
);

`default_nettype wire
